/* hdl/huffman_table_decoder_core_defines.svh */
// assertion macros used by the decoder core rtl
`ifndef HUFFMAN_TABLE_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TABLE_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold in the same cycle
`define HTD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// consequence that must hold in the cycle after the condition
`define HTD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define HTD_ASSERT(label, prop, msg)
`define HTD_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

/* hdl/htd_pkg.sv */
`timescale 1ns / 1ps

package htd_pkg;

    // input word field offsets in s_tdata, lowest bit up
    localparam int IDX_LSB  = 0;
    localparam int SYM_LSB  = 8;
    localparam int LEN_LSB  = 16;
    localparam int CODE_LSB = 22;
    localparam int BIT_LSB  = 54;
    localparam int IN_DATA_W = 56;

    // op codes carried in s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } htd_state_t;

    // table write broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [7:0]  index;
        logic [7:0]  sym;
        logic [5:0]  len;
        logic [31:0] code;
    } htd_load_t;

    // search wave handed from cell to cell
    typedef struct packed {
        logic       hit;
        logic [7:0] sym;
    } htd_link_t;

endpackage

/* hdl/huffman_table_decoder_core.sv */
`timescale 1ns / 1ps
// Huffman decoder over a loaded code table held in a row of TABLE_DEPTH cells,
// one table entry per cell. A load word (s_tuser = 0) writes one entry. A
// decode word (s_tuser = 1) appends one bit to the prefix; a search wave then
// walks the cell row one cell per cycle, and no word is taken until the wave
// has passed the last cell and, on a match, the symbol has moved into the
// output register, which waits for m_tready while it still holds an older
// word. A word arriving with a full prefix of MAX_CODE_LEN bits gives an error
// word (m_tuser = 1, symbol 0) through the same output register, and drops its
// bit. The first matching entry in index order wins; entries at or above
// entry_count are skipped. Unloaded entries must not be searched.

`include "huffman_table_decoder_core_defines.svh"

module huffman_table_decoder_core #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: entry_count
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index, entry_symbol, entry_length, entry_code, bit_in, zero pad
    input  logic [55:0] s_tdata,
    // op
    input  logic [0:0]  s_tuser,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // symbol
    output logic [7:0]  m_tdata,
    // error
    output logic [0:0]  m_tuser
);
    import htd_pkg::*;

    localparam int CW   = (MAX_CODE_LEN > 32) ? MAX_CODE_LEN : 32;
    localparam int PLW  = $clog2(MAX_CODE_LEN + 1);
    localparam int CNTW = $clog2(TABLE_DEPTH + 1);

    htd_state_t      state_reg, state_next;
    logic [8:0]      count_reg;
    logic [CW-1:0]   prefix_reg, prefix_next;
    logic [CW-1:0]   mask_reg, mask_next;
    logic [PLW-1:0]  plen_reg, plen_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [7:0]      res_sym_reg, res_sym_next;
    logic            res_err_reg, res_err_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_sym_reg, m_sym_next;
    logic            m_err_reg, m_err_next;
    logic            s_accept;
    logic            overflow;
    htd_load_t       load;
    htd_link_t       chain [TABLE_DEPTH+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign overflow = (plen_reg == PLW'(MAX_CODE_LEN));

    // table write broadcast
    always_comb begin
        load.en    = s_accept && (s_tuser[0] == OP_LOAD);
        load.index = s_tdata[IDX_LSB +: 8];
        load.sym   = s_tdata[SYM_LSB +: 8];
        load.len   = s_tdata[LEN_LSB +: 6];
        load.code  = s_tdata[CODE_LSB +: 32];
    end

    // cell row, the wave enters at cell 0 with no hit
    assign chain[0] = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        htd_cell #(
            .INDEX (i),
            .CW    (CW),
            .PLW   (PLW)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .load        (load),
            .entry_count (count_reg),
            .prefix      (prefix_reg),
            .mask        (mask_reg),
            .plen        (plen_reg),
            .link_in     (chain[i]),
            .link_out    (chain[i+1])
        );
    end

    // entry count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // sequencer state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prefix_reg  <= '0;
            mask_reg    <= '0;
            plen_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prefix_reg  <= prefix_next;
            mask_reg    <= mask_next;
            plen_reg    <= plen_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        res_sym_reg <= res_sym_next;
        res_err_reg <= res_err_next;
        m_sym_reg   <= m_sym_next;
        m_err_reg   <= m_err_next;
    end

    // next state, prefix update and output register
    always_comb begin
        state_next   = state_reg;
        prefix_next  = prefix_reg;
        mask_next    = mask_reg;
        plen_next    = plen_reg;
        cnt_next     = cnt_reg;
        res_sym_next = res_sym_reg;
        res_err_next = res_err_reg;
        m_valid_next = m_valid_reg;
        m_sym_next   = m_sym_reg;
        m_err_next   = m_err_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_tuser[0] == OP_DECODE) begin
                    if (overflow) begin
                        prefix_next  = '0;
                        mask_next    = '0;
                        plen_next    = '0;
                        res_sym_next = '0;
                        res_err_next = 1'b1;
                        state_next   = ST_EMIT;
                    end else begin
                        prefix_next = {prefix_reg[CW-2:0], s_tdata[BIT_LSB]};
                        mask_next   = {mask_reg[CW-2:0], 1'b1};
                        plen_next   = plen_reg + 1'b1;
                        cnt_next    = '0;
                        state_next  = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                cnt_next = cnt_reg + 1'b1;
                // wave has passed the last cell with this prefix
                if (cnt_reg == CNTW'(TABLE_DEPTH)) begin
                    if (chain[TABLE_DEPTH].hit) begin
                        prefix_next  = '0;
                        mask_next    = '0;
                        plen_next    = '0;
                        res_sym_next = chain[TABLE_DEPTH].sym;
                        res_err_next = 1'b0;
                        state_next   = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sym_next   = res_sym_reg;
                    m_err_next   = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_sym_reg;
    assign m_tuser[0] = m_err_reg;

    // checks
    `HTD_ASSERT(a_plen_bound, plen_reg <= PLW'(MAX_CODE_LEN), "prefix length past maximum")
    `HTD_ASSERT(a_err_sym_zero, !(m_tvalid && m_tuser[0]) || m_tdata == 8'd0, "error word with symbol")
    `HTD_ASSERT(a_cnt_bound, state_reg != ST_SEARCH || cnt_reg <= CNTW'(TABLE_DEPTH), "search count overrun")
    `HTD_ASSERT_NEXT(a_decode_search, s_accept && s_tuser[0] == OP_DECODE && !overflow, state_reg == ST_SEARCH, "decode did not start search")

endmodule

/* hdl/htd_cell.sv */
`timescale 1ns / 1ps

module htd_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 32,
    parameter int PLW   = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  htd_pkg::htd_load_t load,
    input  logic [8:0]         entry_count,
    input  logic [CW-1:0]      prefix,
    input  logic [CW-1:0]      mask,
    input  logic [PLW-1:0]     plen,
    input  htd_pkg::htd_link_t link_in,
    output htd_pkg::htd_link_t link_out
);
    import htd_pkg::*;

    localparam int CMPW = (PLW > 6) ? PLW : 6;

    logic [7:0]  sym_reg;
    logic [5:0]  len_reg;
    logic [31:0] code_reg;
    htd_link_t   link_reg;
    htd_link_t   link_next;
    logic        active;
    logic        match;

    // table entry held by this cell
    always_ff @(posedge aclk) begin
        if (load.en && load.index == 8'(INDEX)) begin
            sym_reg  <= load.sym;
            len_reg  <= load.len;
            code_reg <= load.code;
        end
    end

    // compare against the current prefix, earlier hit wins
    always_comb begin
        active = entry_count > 9'(INDEX);
        match  = active && (CMPW'(len_reg) == CMPW'(plen))
                 && ((CW'(code_reg) & mask) == prefix);
        link_next = link_in;
        if (!link_in.hit && match) begin
            link_next.hit = 1'b1;
            link_next.sym = sym_reg;
        end
    end

    // wave register toward the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import htd_pkg::*;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int CLK_PERIOD   = 8;
    // a decode word walks the whole cell row before the next word is taken
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int TIMEOUT_NS    = 20_000_000;

    // one word on the input channel, fields unpacked
    typedef struct {
        logic        op;
        logic [7:0]  idx;
        logic [7:0]  sym;
        logic [5:0]  len;
        logic [31:0] code;
        logic        bit_in;
    } stream_word_t;

    // one word on the result channel
    typedef struct {
        logic [7:0] sym;
        logic       err;
    } symbol_result_t;

    // tracks the code table and prefix, predicts symbols and checks them in order
    class symbol_scoreboard;
        bit [7:0]       slot_sym  [TABLE_DEPTH];
        bit [5:0]       slot_len  [TABLE_DEPTH];
        bit [31:0]      slot_code [TABLE_DEPTH];
        bit [31:0]      prefix_bits;
        int unsigned    prefix_len;
        int unsigned    entry_count;
        symbol_result_t pending_symbols[$];
        int unsigned    mismatches;

        function void set_entry_count(bit [8:0] value);
            entry_count = value;
        endfunction

        // apply one accepted input word, queue the symbol it yields if any
        function void note_word(stream_word_t w);
            symbol_result_t res;
            bit [63:0]      mask;
            int unsigned    lim;
            int unsigned    i;
            if (w.op == OP_LOAD) begin
                slot_sym[w.idx]  = w.sym;
                slot_len[w.idx]  = w.len;
                slot_code[w.idx] = w.code;
                return;
            end
            res.sym = 8'h00;
            res.err = 1'b1;
            // full prefix: error word, incoming bit dropped
            if (prefix_len >= MAX_CODE_LEN) begin
                prefix_bits = '0;
                prefix_len  = 0;
                pending_symbols.push_back(res);
                return;
            end
            prefix_bits = {prefix_bits[30:0], w.bit_in};
            prefix_len++;
            lim = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
            // first entry in index order with equal length and bits wins
            for (i = 0; i < lim; i++) begin
                if (slot_len[i] != prefix_len)
                    continue;
                mask = (64'd1 << slot_len[i]) - 64'd1;
                if ((slot_code[i] & mask[31:0]) == prefix_bits) begin
                    res.sym = slot_sym[i];
                    res.err = 1'b0;
                    pending_symbols.push_back(res);
                    prefix_bits = '0;
                    prefix_len  = 0;
                    return;
                end
            end
        endfunction

        // compare one result word with the oldest predicted one
        function void check_result(logic [7:0] sym, logic err);
            symbol_result_t want;
            if (pending_symbols.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: symbol %02h error %0b", sym, err);
                return;
            end
            want = pending_symbols.pop_front();
            if (sym !== want.sym || err !== want.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: symbol %02h error %0b, expected symbol %02h error %0b",
                             sym, err, want.sym, want.err);
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata     = '0;
    logic [0:0]  s_tuser     = OP_LOAD;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;

    symbol_scoreboard board = new();
    int unsigned      words_sent        = 0;
    int unsigned      decodes_sent      = 0;
    int unsigned      sender_idle_pct   = 28;
    int unsigned      receiver_idle_pct = 82;

    huffman_table_decoder_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // clock
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser[0]);
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // keep stray bits above the code length random
    function automatic bit [31:0] with_stray(input bit [31:0] code, input int unsigned len);
        if (len >= 32)
            return code;
        return (code & ((32'd1 << len) - 32'd1)) | ($urandom() << len);
    endfunction

    // a length that can never match: zero or longer than the longest code
    function automatic bit [5:0] junk_length();
        return ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
    endfunction

    // push one word through the input channel with random gaps
    task automatic send_word(input stream_word_t w);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IDX_LSB +: 8]   = w.idx;
        d[SYM_LSB +: 8]   = w.sym;
        d[LEN_LSB +: 6]   = w.len;
        d[CODE_LSB +: 32] = w.code;
        d[BIT_LSB]        = w.bit_in;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= w.op;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_word(w);
        words_sent++;
        if (w.op == OP_DECODE)
            decodes_sent++;
        // idle pattern moves on as the bit stream progresses
        if (decodes_sent < 150) begin
            sender_idle_pct   = 28;
            receiver_idle_pct = 82;
        end else if (decodes_sent < 300) begin
            sender_idle_pct   = 82;
            receiver_idle_pct = 28;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
    endtask

    task automatic load_slot(input bit [7:0] idx, input bit [7:0] sym, input bit [5:0] len,
                             input bit [31:0] code);
        stream_word_t w;
        w.op     = OP_LOAD;
        w.idx    = idx;
        w.sym    = sym;
        w.len    = len;
        w.code   = code;
        w.bit_in = 1'($urandom_range(1));
        send_word(w);
    endtask

    // decode word, unused fields random
    task automatic decode_bit(input logic b);
        stream_word_t w;
        w.op     = OP_DECODE;
        w.idx    = 8'($urandom());
        w.sym    = 8'($urandom());
        w.len    = 6'($urandom());
        w.code   = $urandom();
        w.bit_in = b;
        send_word(w);
    endtask

    // stop sending until every symbol is back and the search has settled
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending_symbols.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called while the block is idle
    task automatic write_count(input bit [8:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        board.set_entry_count(value);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // random prefix code tree in slots 0 up, with a few holes, a shadowed copy and a dud
    task automatic load_tree_table(input int unsigned n_leaves, output int unsigned n_slots);
        bit [31:0]   leaf_code [64];
        int unsigned leaf_len  [64];
        int unsigned n;
        int unsigned j;
        int unsigned s;
        leaf_code[0] = 32'd0;
        leaf_len[0]  = 1;
        leaf_code[1] = 32'd1;
        leaf_len[1]  = 1;
        n = 2;
        while (n < n_leaves) begin
            j = $urandom_range(n - 1);
            if (leaf_len[j] < MAX_CODE_LEN) begin
                leaf_code[n] = (leaf_code[j] << 1) | 32'd1;
                leaf_len[n]  = leaf_len[j] + 1;
                leaf_code[j] = leaf_code[j] << 1;
                leaf_len[j]  = leaf_len[j] + 1;
                n++;
            end
        end
        for (s = 0; s < n; s++) begin
            if ($urandom_range(9) == 0)
                load_slot(8'(s), 8'($urandom()), junk_length(), $urandom());
            else
                load_slot(8'(s), 8'($urandom()), 6'(leaf_len[s]),
                          with_stray(leaf_code[s], leaf_len[s]));
        end
        j = $urandom_range(n - 1);
        load_slot(8'(n), 8'($urandom()), 6'(leaf_len[j]),
                  with_stray(leaf_code[j], leaf_len[j]));
        load_slot(8'(n + 1), 8'($urandom()), junk_length(), $urandom());
        n_slots = n + 2;
    endtask

    // bit stream built mostly from codes of searched slots, with noise and rewrites
    task automatic run_stream(input int unsigned n_bits, input int unsigned span);
        int unsigned sent;
        int unsigned r;
        int unsigned s;
        int unsigned tries;
        int unsigned j;
        int unsigned n;
        bit          found;
        sent = 0;
        while (sent < n_bits) begin
            r     = $urandom_range(99);
            found = 1'b0;
            s     = 0;
            if (r < 80) begin
                for (tries = 0; tries < 8 && !found; tries++) begin
                    s = $urandom_range(span - 1);
                    if (board.slot_len[s] >= 1 && board.slot_len[s] <= MAX_CODE_LEN)
                        found = 1'b1;
                end
            end
            if (found) begin
                n = board.slot_len[s];
                for (j = n; j > 0; j--)
                    decode_bit(board.slot_code[s][j - 1]);
                sent += n;
            end else if (r < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) decode_bit(1'($urandom_range(1)));
                sent += n;
            end else if (r < 95) begin
                // rewrite a searched slot mid-stream
                s = $urandom_range(span - 1);
                if ($urandom_range(9) == 0)
                    load_slot(8'(s), 8'($urandom()), junk_length(), $urandom());
                else begin
                    n = $urandom_range(1, 16);
                    load_slot(8'(s), 8'($urandom()), 6'(n), with_stray($urandom(), n));
                end
            end else if (r < 98) begin
                // long noise, most likely runs the prefix into overflow
                n = $urandom_range(33, 36);
                repeat (n) decode_bit(1'($urandom_range(1)));
                sent += n;
            end else begin
                drain_results();
            end
        end
    endtask

    // stimulus
    initial begin
        int unsigned n_slots;
        int unsigned span;
        int unsigned i;
        int unsigned pick;
        bit [8:0]    count;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty search, stray bits, zero and long lengths, shadowed duplicate
        write_count(9'd0);
        decode_bit(1'b1);
        load_slot(8'd0, 8'hA5, 6'd1,  32'hFFFF_FFFE);
        load_slot(8'd1, 8'h00, 6'd0,  32'h0000_0000);
        load_slot(8'd2, 8'hFF, 6'd63, 32'hFFFF_FFFF);
        load_slot(8'd3, 8'h3C, 6'd32, 32'hFFFF_FFFF);
        load_slot(8'd4, 8'h5A, 6'd2,  32'h0000_0002);
        load_slot(8'd5, 8'h11, 6'd2,  32'h0000_0002);
        load_slot(8'd6, 8'h80, 6'd33, 32'h0000_0001);
        drain_results();
        write_count(9'd7);
        decode_bit(1'b0);
        decode_bit(1'b0);
        decode_bit(1'b1);
        decode_bit(1'b0);

        // long codes, a full 32-bit code among them, overflow from noise
        load_slot(8'd0, 8'($urandom()), 6'd32, $urandom());
        for (i = 1; i < 6; i++) begin
            pick = $urandom_range(20, 32);
            load_slot(8'(i), 8'($urandom()), 6'(pick), with_stray($urandom(), pick));
        end
        drain_results();
        write_count(9'd6);
        run_stream(120, 6);

        // small trees, then a single searched slot
        load_tree_table(8, n_slots);
        drain_results();
        write_count(9'(n_slots));
        run_stream(60, n_slots);
        load_tree_table(5, n_slots);
        drain_results();
        write_count(9'd1);
        run_stream(40, 1);

        // every slot filled with an 8-bit code, searched in full and with count past depth
        for (i = 0; i < TABLE_DEPTH; i++)
            load_slot(8'(i), 8'($urandom()), 6'd8, with_stray(i, 8));
        drain_results();
        write_count(9'd256);
        run_stream(60, TABLE_DEPTH);
        drain_results();
        write_count(9'd511);
        run_stream(60, TABLE_DEPTH);

        // fresh random trees until the word budget is spent
        while (words_sent < 760) begin
            load_tree_table($urandom_range(2, 24), n_slots);
            drain_results();
            pick = $urandom_range(7);
            if (pick < 5)
                count = 9'(n_slots);
            else if (pick == 5)
                count = 9'($urandom_range(1, n_slots));
            else if (pick == 6)
                count = 9'd256;
            else
                count = 9'($urandom_range(257, 511));
            write_count(count);
            span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            run_stream(50, span);
        end

        drain_results();
        if (board.mismatches == 0 && board.pending_symbols.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
